### rtl/core/lvrd_pkg.sv
// Shared types and constants of the local velocity RMS deviation unit.
package lvrd_pkg;

	localparam int SW          = 24;
	localparam int FLOOR_W     = 16;
	localparam int RMS_W       = 25;
	localparam int TOTAL_W     = 5;
	localparam logic [FLOOR_W-1:0] FLOOR_RESET = 16'd1;
	localparam logic [1:0] COMP_LAST = 2'd2;

	typedef struct packed {
		logic signed [SW-1:0] vel_x;
		logic signed [SW-1:0] vel_y;
		logic signed [SW-1:0] vel_z;
		logic                 last_sample;
	} sample_t;

	typedef struct packed {
		logic [RMS_W-1:0]   rms_deviation;
		logic [TOTAL_W-1:0] sample_total;
		logic               overflow;
	} result_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MEAN_GO,
		ST_MEAN_WAIT,
		ST_PASS,
		ST_DRAIN,
		ST_VAR_GO,
		ST_VAR_WAIT,
		ST_THIRD_GO,
		ST_THIRD_WAIT,
		ST_SQRT_GO,
		ST_SQRT_WAIT,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic       load;
		logic       mean_start;
		logic       mean_cap;
		logic       rd_en;
		logic       var_start;
		logic       var_cap;
		logic       third_start;
		logic       sqrt_start;
		logic       finish;
		logic [1:0] comp;
	} cmd_t;

	typedef struct packed {
		logic div_busy;
		logic third_busy;
		logic sqrt_busy;
		logic pipe_empty;
		logic rd_last;
	} status_t;

endpackage

### rtl/core/lvrd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lvrd_ram #(
	parameter int WIDTH = 72,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### rtl/core/lvrd_div.sv
// Iterative restoring unsigned divider, one quotient bit per cycle.
module lvrd_div #(
	parameter int N_W = 52,
	parameter int D_W = 5
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [N_W-1:0] dividend,
	input  logic [D_W-1:0] divisor,
	output logic           busy,
	output logic [N_W-1:0] quotient
);

	localparam int C_W = $clog2(N_W + 1);

	logic [N_W-1:0] quo_q;
	logic [D_W-1:0] rem_q;
	logic [D_W-1:0] div_q;
	logic [C_W-1:0] cnt_q;
	logic           busy_q;
	logic [D_W:0]   trial;
	logic [D_W:0]   diff;
	logic           ge;

	assign trial = {rem_q, quo_q[N_W-1]};
	assign diff  = trial - {1'b0, div_q};
	assign ge    = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= C_W'(N_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == C_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[N_W-2:0], ge};
			rem_q <= ge ? diff[D_W-1:0] : trial[D_W-1:0];
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule

### rtl/core/lvrd_sqrt.sv
// Iterative floored integer square root, two radicand bits per cycle.
module lvrd_sqrt #(
	parameter int W = 48
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [W-1:0]     radicand,
	output logic             busy,
	output logic [W/2-1:0]   root
);

	localparam int C_W = $clog2(W / 2 + 1);

	logic [W-1:0]   x_q;
	logic [W-1:0]   res_q;
	logic [W-1:0]   bit_q;
	logic [C_W-1:0] cnt_q;
	logic           busy_q;
	logic [W-1:0]   trial;

	assign trial = res_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= C_W'(W / 2);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == C_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= radicand;
			res_q <= '0;
			bit_q <= W'(1) << (W - 2);
		end else if (busy_q) begin
			if (x_q >= trial) begin
				x_q   <= x_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign busy = busy_q;
	assign root = res_q[W/2-1:0];

endmodule

### rtl/core/lvrd_ctrl.sv
// Controller state machine sequencing load, mean, deviation pass, divisions and root.
module lvrd_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             last_sample,
	input  lvrd_pkg::status_t status,
	output lvrd_pkg::cmd_t   cmd,
	output logic             busy
);

	lvrd_pkg::state_t state_q, state_d;
	logic [1:0]       comp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lvrd_pkg::ST_IDLE;
			comp_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == lvrd_pkg::ST_VAR_WAIT && !status.div_busy) begin
				comp_q <= (comp_q == lvrd_pkg::COMP_LAST) ? 2'd0 : comp_q + 2'd1;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lvrd_pkg::ST_IDLE: begin
				if (start && last_sample) state_d = lvrd_pkg::ST_MEAN_GO;
			end
			lvrd_pkg::ST_MEAN_GO:   state_d = lvrd_pkg::ST_MEAN_WAIT;
			lvrd_pkg::ST_MEAN_WAIT: begin
				if (!status.div_busy) state_d = lvrd_pkg::ST_PASS;
			end
			lvrd_pkg::ST_PASS: begin
				if (status.rd_last) state_d = lvrd_pkg::ST_DRAIN;
			end
			lvrd_pkg::ST_DRAIN: begin
				if (status.pipe_empty) state_d = lvrd_pkg::ST_VAR_GO;
			end
			lvrd_pkg::ST_VAR_GO:    state_d = lvrd_pkg::ST_VAR_WAIT;
			lvrd_pkg::ST_VAR_WAIT: begin
				if (!status.div_busy) begin
					state_d = (comp_q == lvrd_pkg::COMP_LAST) ?
						lvrd_pkg::ST_THIRD_GO : lvrd_pkg::ST_MEAN_GO;
				end
			end
			lvrd_pkg::ST_THIRD_GO:  state_d = lvrd_pkg::ST_THIRD_WAIT;
			lvrd_pkg::ST_THIRD_WAIT: begin
				if (!status.third_busy) state_d = lvrd_pkg::ST_SQRT_GO;
			end
			lvrd_pkg::ST_SQRT_GO:   state_d = lvrd_pkg::ST_SQRT_WAIT;
			lvrd_pkg::ST_SQRT_WAIT: begin
				if (!status.sqrt_busy) state_d = lvrd_pkg::ST_FINISH;
			end
			lvrd_pkg::ST_FINISH:    state_d = lvrd_pkg::ST_IDLE;
			default:                state_d = lvrd_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		cmd.comp = comp_q;
		busy     = 1'b1;
		unique case (state_q)
			lvrd_pkg::ST_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			lvrd_pkg::ST_MEAN_GO:    cmd.mean_start  = 1'b1;
			lvrd_pkg::ST_MEAN_WAIT:  cmd.mean_cap    = !status.div_busy;
			lvrd_pkg::ST_PASS:       cmd.rd_en       = 1'b1;
			lvrd_pkg::ST_DRAIN:      cmd.rd_en       = 1'b0;
			lvrd_pkg::ST_VAR_GO:     cmd.var_start   = 1'b1;
			lvrd_pkg::ST_VAR_WAIT:   cmd.var_cap     = !status.div_busy;
			lvrd_pkg::ST_THIRD_GO:   cmd.third_start = 1'b1;
			lvrd_pkg::ST_THIRD_WAIT: cmd.rd_en       = 1'b0;
			lvrd_pkg::ST_SQRT_GO:    cmd.sqrt_start  = 1'b1;
			lvrd_pkg::ST_SQRT_WAIT:  cmd.rd_en       = 1'b0;
			lvrd_pkg::ST_FINISH:     cmd.finish      = 1'b1;
			default:                 busy            = 1'b1;
		endcase
	end

	property p_load_idle;
		@(posedge clk) disable iff (!arst_n) cmd.load |-> state_q == lvrd_pkg::ST_IDLE;
	endproperty
	a_load_idle: assert property (p_load_idle) else $error("load outside idle");

	property p_pass_comp;
		@(posedge clk) disable iff (!arst_n)
			(state_q == lvrd_pkg::ST_PASS) |-> comp_q != 2'd3;
	endproperty
	a_pass_comp: assert property (p_pass_comp) else $error("bad component index");

	property p_finish_idle;
		@(posedge clk) disable iff (!arst_n)
			cmd.finish |=> state_q == lvrd_pkg::ST_IDLE && comp_q == 2'd0;
	endproperty
	a_finish_idle: assert property (p_finish_idle) else $error("finish did not return");

endmodule

### rtl/core/lvrd_dp.sv
// Datapath: sample store, running sums, deviation pipeline, divider and root units.
module lvrd_dp #(
	parameter int MAX_NODES = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  lvrd_pkg::cmd_t                    cmd,
	input  lvrd_pkg::sample_t                 sample,
	input  logic                              cfg_we,
	input  logic [lvrd_pkg::FLOOR_W-1:0]      cfg_data,
	output lvrd_pkg::status_t                 status,
	output logic                              done,
	output lvrd_pkg::result_t                 result
);

	localparam int SW     = lvrd_pkg::SW;
	localparam int IDX_W  = $clog2(MAX_NODES);
	localparam int CNT_W  = $clog2(MAX_NODES + 1);
	localparam int SUM_W  = SW + IDX_W;
	localparam int ACC_W  = 2 * SW + IDX_W;
	localparam int TOT_W  = 2 * SW + 2;
	localparam int DIV_W  = (ACC_W > TOT_W) ? ACC_W : TOT_W;
	localparam int RT_W   = 2 * SW;
	localparam int R_W    = ((SW > lvrd_pkg::FLOOR_W) ? SW : lvrd_pkg::FLOOR_W) + 1;
	// The division by three works on ten-bit chunks, one chunk a cycle.
	localparam int D3_CH  = (TOT_W + 9) / 10;
	localparam int D3_PW  = D3_CH * 10;
	localparam int D3_CW  = $clog2(D3_CH + 1);
	localparam logic [11:0] D3_RECIP = 12'd2731;

	logic signed [SUM_W-1:0] sums_q [3];
	logic [CNT_W-1:0]        count_q;
	logic [CNT_W-1:0]        rd_idx_q;
	logic                    dropped_q;
	logic [lvrd_pkg::FLOOR_W-1:0] floor_q;
	logic signed [SW-1:0]    mean_q;
	logic [ACC_W-1:0]        acc_q;
	logic [TOT_W-1:0]        total_q;
	logic                    v_s1, v_s2, v_s3;
	logic [SW-1:0]           mag_s2;
	logic [2*SW-1:0]         sq_s3;
	logic                    done_q;
	lvrd_pkg::result_t       result_q;
	logic [D3_PW-1:0]        d3_x_q;
	logic [D3_PW-1:0]        d3_quo_q;
	logic [1:0]              d3_rem_q;
	logic [D3_CW-1:0]        d3_cnt_q;
	logic                    d3_busy_q;

	logic                    room;
	logic [3*SW-1:0]         rdata;
	logic signed [SUM_W-1:0] sum_sel;
	logic                    sum_neg;
	logic [SUM_W-1:0]        sum_mag;
	logic                    div_start;
	logic [DIV_W-1:0]        dividend;
	logic [CNT_W-1:0]        divisor;
	logic                    div_busy;
	logic [DIV_W-1:0]        quotient;
	logic [SW-1:0]           q_low;
	logic                    sqrt_busy;
	logic [SW-1:0]           root;
	logic signed [SW-1:0]    field;
	logic signed [SW:0]      diff;
	logic [SW:0]             diff_mag;
	logic [R_W-1:0]          r_base;
	logic [R_W-1:0]          r_final;
	logic [11:0]             d3_v;
	logic [23:0]             d3_prod;
	logic [9:0]              d3_digit;
	logic [11:0]             d3_three;
	logic [11:0]             d3_left;

	assign room = count_q < CNT_W'(MAX_NODES);

	always_comb begin
		case (cmd.comp)
			2'd0:    sum_sel = sums_q[0];
			2'd1:    sum_sel = sums_q[1];
			default: sum_sel = sums_q[2];
		endcase
	end
	assign sum_neg = sum_sel[SUM_W-1];
	assign sum_mag = sum_neg ? SUM_W'(-sum_sel) : SUM_W'(sum_sel);

	assign div_start = cmd.mean_start | cmd.var_start;
	always_comb begin
		dividend = DIV_W'(acc_q);
		divisor  = count_q;
		if (cmd.mean_start) begin
			dividend = DIV_W'(sum_mag);
		end
	end

	lvrd_div #(.N_W(DIV_W), .D_W(CNT_W)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.divisor  (divisor),
		.busy     (div_busy),
		.quotient (quotient)
	);

	// Each chunk step divides the carried remainder and ten new bits by three
	// with a reciprocal multiply, exact for every value below 3072.
	assign d3_v     = {d3_rem_q, d3_x_q[D3_PW-1 -: 10]};
	assign d3_prod  = {12'd0, d3_v} * {12'd0, D3_RECIP};
	assign d3_digit = d3_prod[22:13];
	assign d3_three = {2'b00, d3_digit} + {1'b0, d3_digit, 1'b0};
	assign d3_left  = d3_v - d3_three;

	lvrd_sqrt #(.W(RT_W)) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.sqrt_start),
		.radicand (d3_quo_q[RT_W-1:0]),
		.busy     (sqrt_busy),
		.root     (root)
	);

	lvrd_ram #(.WIDTH(3 * SW), .DEPTH(MAX_NODES)) u_store (
		.clk   (clk),
		.we    (cmd.load & room),
		.waddr (count_q[IDX_W-1:0]),
		.wdata ({sample.vel_z, sample.vel_y, sample.vel_x}),
		.re    (cmd.rd_en),
		.raddr (rd_idx_q[IDX_W-1:0]),
		.rdata (rdata)
	);

	assign q_low = quotient[SW-1:0];

	always_comb begin
		case (cmd.comp)
			2'd0:    field = rdata[SW-1:0];
			2'd1:    field = rdata[2*SW-1:SW];
			default: field = rdata[3*SW-1:2*SW];
		endcase
	end
	assign diff     = (SW+1)'(field) - (SW+1)'(mean_q);
	assign diff_mag = diff[SW] ? (SW+1)'(-diff) : (SW+1)'(diff);

	assign r_base  = R_W'(root);
	assign r_final = (r_base < R_W'(floor_q)) ? r_base + R_W'(floor_q) : r_base;

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sums_q[0] <= '0;
			sums_q[1] <= '0;
			sums_q[2] <= '0;
			count_q   <= '0;
			dropped_q <= 1'b0;
			floor_q   <= lvrd_pkg::FLOOR_RESET;
			rd_idx_q  <= '0;
			total_q   <= '0;
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			done_q    <= 1'b0;
			d3_busy_q <= 1'b0;
			d3_cnt_q  <= '0;
		end else begin
			if (cfg_we) floor_q <= cfg_data;
			if (cmd.load) begin
				if (room) begin
					sums_q[0] <= sums_q[0] + SUM_W'(sample.vel_x);
					sums_q[1] <= sums_q[1] + SUM_W'(sample.vel_y);
					sums_q[2] <= sums_q[2] + SUM_W'(sample.vel_z);
					count_q   <= count_q + 1'b1;
				end else begin
					dropped_q <= 1'b1;
				end
			end
			if (cmd.mean_start) begin
				rd_idx_q <= '0;
			end else if (cmd.rd_en) begin
				rd_idx_q <= rd_idx_q + 1'b1;
			end
			v_s1 <= cmd.rd_en;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (cmd.var_cap) begin
				total_q <= total_q + TOT_W'(quotient);
			end
			if (cmd.third_start) begin
				d3_busy_q <= 1'b1;
				d3_cnt_q  <= D3_CW'(D3_CH);
			end else if (d3_busy_q) begin
				d3_cnt_q <= d3_cnt_q - 1'b1;
				if (d3_cnt_q == D3_CW'(1)) begin
					d3_busy_q <= 1'b0;
				end
			end
			done_q <= cmd.finish;
			if (cmd.finish) begin
				sums_q[0] <= '0;
				sums_q[1] <= '0;
				sums_q[2] <= '0;
				count_q   <= '0;
				dropped_q <= 1'b0;
				total_q   <= '0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (cmd.mean_cap) begin
			mean_q <= sum_neg ? SW'(-q_low) : SW'(q_low);
		end
		if (v_s1) mag_s2 <= diff_mag[SW-1:0];
		if (v_s2) sq_s3 <= mag_s2 * mag_s2;
		if (cmd.mean_start) begin
			acc_q <= '0;
		end else if (v_s3) begin
			acc_q <= acc_q + ACC_W'(sq_s3);
		end
		if (cmd.third_start) begin
			d3_x_q   <= D3_PW'(total_q);
			d3_rem_q <= '0;
		end else if (d3_busy_q) begin
			d3_x_q   <= d3_x_q << 10;
			d3_quo_q <= {d3_quo_q[D3_PW-11:0], d3_digit};
			d3_rem_q <= d3_left[1:0];
		end
		if (cmd.finish) begin
			result_q.rms_deviation <= lvrd_pkg::RMS_W'(r_final);
			result_q.sample_total  <= lvrd_pkg::TOTAL_W'(count_q);
			result_q.overflow      <= dropped_q;
		end
	end

	assign status.div_busy   = div_busy;
	assign status.third_busy = d3_busy_q;
	assign status.sqrt_busy  = sqrt_busy;
	assign status.pipe_empty = !v_s1 && !v_s2 && !v_s3;
	assign status.rd_last    = CNT_W'(rd_idx_q + 1'b1) == count_q;
	assign done   = done_q;
	assign result = result_q;

	property p_count_bound;
		@(posedge clk) disable iff (!arst_n) count_q <= CNT_W'(MAX_NODES);
	endproperty
	a_count_bound: assert property (p_count_bound) else $error("sample count overrun");

	property p_pass_nonempty;
		@(posedge clk) disable iff (!arst_n) cmd.mean_start |-> count_q != '0;
	endproperty
	a_pass_nonempty: assert property (p_pass_nonempty) else $error("empty set closed");

	property p_rd_in_range;
		@(posedge clk) disable iff (!arst_n) cmd.rd_en |-> rd_idx_q < count_q;
	endproperty
	a_rd_in_range: assert property (p_rd_in_range) else $error("read past stored samples");

endmodule

### rtl/core/local_velocity_rms_deviation_unit.sv
// Top level of the local velocity RMS deviation unit.
//
//   channel   direction  handshake           payload
//   sample    in         start & !busy       lvrd_pkg::sample_t
//   result    out        done (one cycle)    lvrd_pkg::result_t
//   config    in         cfg_valid & ready   cfg_data (floor value, Q.16)
//
// Every sample request is taken in the cycle it is made; busy stays low while a set is loading.
// The request that closes a set starts the computation, which holds busy high
// up to the last step. For each component in turn it runs the shared
// bit-serial divider (one quotient bit a cycle, 52 bits) for the mean, a pass
// over the sample store (one read a cycle) and the divider again for the
// variance; the divide by three and the root follow.
// The result strobe follows in the cycle after the last step.
// Reset clears the set and restores the floor value to one; the store itself
// needs no clearing, since only entries written in the open set are read.
// The receiver cannot stall the result, so done lasts exactly one cycle.
module local_velocity_rms_deviation_unit #(
	parameter int MAX_NODES = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  lvrd_pkg::sample_t             sample,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [lvrd_pkg::FLOOR_W-1:0]  cfg_data,
	output logic                          done,
	output lvrd_pkg::result_t             result
);

	lvrd_pkg::cmd_t    cmd;
	lvrd_pkg::status_t status;

	// The floor register accepts a write in any cycle.
	assign cfg_ready = 1'b1;

	// The controller sequences each closed set through its phases.
	lvrd_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.last_sample (sample.last_sample),
		.status      (status),
		.cmd         (cmd),
		.busy        (busy)
	);

	// The datapath holds the set, the arithmetic units and the result register.
	lvrd_dp #(.MAX_NODES(MAX_NODES)) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sample   (sample),
		.cfg_we   (cfg_valid & cfg_ready),
		.cfg_data (cfg_data),
		.status   (status),
		.done     (done),
		.result   (result)
	);

	property p_done_idle;
		@(posedge clk) disable iff (!arst_n) done |-> !busy;
	endproperty
	a_done_idle: assert property (p_done_idle) else $error("result while busy");

	property p_done_single;
		@(posedge clk) disable iff (!arst_n) done |=> !done;
	endproperty
	a_done_single: assert property (p_done_single) else $error("result strobe repeated");

	property p_close_busy;
		@(posedge clk) disable iff (!arst_n)
			(start && !busy && sample.last_sample) |=> busy;
	endproperty
	a_close_busy: assert property (p_close_busy) else $error("closing request not taken up");

endmodule

### dv/local_velocity_rms_deviation_unit_tb.sv
// Self-checking testbench of the local velocity RMS deviation unit.
module local_velocity_rms_deviation_unit_tb;

	localparam int NODES = 16;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	lvrd_pkg::sample_t sample;
	logic cfg_valid;
	logic cfg_ready;
	logic [lvrd_pkg::FLOOR_W-1:0] cfg_data;
	logic done;
	lvrd_pkg::result_t result;

	local_velocity_rms_deviation_unit #(.MAX_NODES(NODES)) u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .sample(sample),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.done(done), .result(result)
	);

	// Predictor state: our own copy of the open set and the floor register.
	logic signed [lvrd_pkg::SW-1:0] set_x [NODES];
	logic signed [lvrd_pkg::SW-1:0] set_y [NODES];
	logic signed [lvrd_pkg::SW-1:0] set_z [NODES];
	int unsigned set_len;
	logic set_dropped;
	logic [lvrd_pkg::FLOOR_W-1:0] floor_reg;

	lvrd_pkg::result_t pending_results [$];
	int mismatch_count;
	int sender_gap_pct;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Safety net: far beyond the slowest legal run.
	initial begin
		#50000000;
		$display("DONE: errors detected");
		$finish;
	end

	// Mean squared deviation of one component, floored, in Q.32 units.
	function automatic longint unsigned component_variance(
			input logic signed [lvrd_pkg::SW-1:0] v [NODES], input int unsigned n);
		longint sum;
		longint mean;
		longint diff;
		longint unsigned acc;
		sum = 0;
		acc = 0;
		for (int i = 0; i < n; i++) sum += v[i];
		mean = sum / longint'(n);
		for (int i = 0; i < n; i++) begin
			diff = longint'(v[i]) - mean;
			acc += longint'(diff * diff);
		end
		return acc / n;
	endfunction

	function automatic longint unsigned floor_sqrt(input longint unsigned x);
		longint unsigned root;
		longint unsigned bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > x) bitv >>= 2;
		while (bitv != 0) begin
			if (x >= root + bitv) begin
				x -= root + bitv;
				root = (root >> 1) + bitv;
			end else begin
				root >>= 1;
			end
			bitv >>= 2;
		end
		return root;
	endfunction

	// Applies one accepted sample to the predictor and queues a result on close.
	task automatic predict_sample(input lvrd_pkg::sample_t s);
		longint unsigned total;
		longint unsigned r;
		lvrd_pkg::result_t exp_res;
		if (set_len < NODES) begin
			set_x[set_len] = s.vel_x;
			set_y[set_len] = s.vel_y;
			set_z[set_len] = s.vel_z;
			set_len++;
		end else begin
			set_dropped = 1'b1;
		end
		if (s.last_sample) begin
			total = component_variance(set_x, set_len) + component_variance(set_y, set_len)
				+ component_variance(set_z, set_len);
			r = floor_sqrt(total / 3);
			if (r < floor_reg) r += floor_reg;
			exp_res.rms_deviation = r[lvrd_pkg::RMS_W-1:0];
			exp_res.sample_total = set_len[lvrd_pkg::TOTAL_W-1:0];
			exp_res.overflow = set_dropped;
			pending_results.push_back(exp_res);
			set_len = 0;
			set_dropped = 1'b0;
		end
	endtask

	// Result checker: every strobe is compared with the oldest expectation.
	always @(posedge clk) begin
		lvrd_pkg::result_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10) $display("unexpected result %p", result);
			end else begin
				want = pending_results.pop_front();
				if (result.rms_deviation !== want.rms_deviation
						|| result.sample_total !== want.sample_total
						|| result.overflow !== want.overflow) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("result mismatch: expected %p, got %p", want, result);
				end
			end
		end
	end

	// Sends one sample request, with random idle cycles ahead of it. Start is
	// left high afterwards, so back-to-back requests follow without a gap.
	task automatic send_sample(input lvrd_pkg::sample_t s);
		while ($urandom_range(99) < sender_gap_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		sample <= s;
		@(posedge clk);
		while (busy) @(posedge clk);
		predict_sample(s);
	endtask

	// Waits until every expected result has come, plus a latency margin.
	task automatic drain_results();
		start <= 1'b0;
		while (pending_results.size() != 0 || busy) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_floor(input logic [lvrd_pkg::FLOOR_W-1:0] value);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		floor_reg = value;
		cfg_valid <= 1'b0;
	endtask

	function automatic lvrd_pkg::sample_t make_sample(input int x, input int y, input int z,
			input bit last);
		lvrd_pkg::sample_t s;
		s.vel_x = x[lvrd_pkg::SW-1:0];
		s.vel_y = y[lvrd_pkg::SW-1:0];
		s.vel_z = z[lvrd_pkg::SW-1:0];
		s.last_sample = last;
		return s;
	endfunction

	function automatic int rand_vel();
		case ($urandom_range(3))
			0: return $urandom_range(1) ? 8388607 : -8388608;
			1: return int'($urandom_range(512)) - 256;
			default: return int'($urandom) >>> 8;
		endcase
	endfunction

	// Directed sets: extreme values, a single sample, identical samples and an
	// over-long set whose closing sample is dropped.
	task automatic test_directed();
		send_sample(make_sample(0, 0, 0, 1'b1));
		send_sample(make_sample(8388607, 8388607, 8388607, 1'b0));
		send_sample(make_sample(-8388608, -8388608, -8388608, 1'b1));
		send_sample(make_sample(-8388608, 8388607, -1, 1'b0));
		send_sample(make_sample(8388607, -8388608, 1, 1'b1));
		send_sample(make_sample(1000, 1000, 1000, 1'b0));
		send_sample(make_sample(1000, 1000, 1000, 1'b1));
		send_sample(make_sample(3, -7, 5, 1'b0));
		send_sample(make_sample(-2, 6, -4, 1'b1));
		for (int i = 0; i < 17; i++)
			send_sample(make_sample(i * 100003 - 800000, -i * 7777, i, i == 16));
	endtask

	// Random sets, mostly short, sometimes full or too long.
	task automatic test_random_sets(input int items);
		int len;
		int sent;
		sent = 0;
		while (sent < items) begin
			case ($urandom_range(9))
				0: len = NODES + $urandom_range(1, 4);
				1: len = NODES;
				default: len = $urandom_range(1, 8);
			endcase
			for (int i = 0; i < len; i++)
				send_sample(make_sample(rand_vel(), rand_vel(), rand_vel(), i == len - 1));
			sent += len;
		end
	endtask

	task automatic test_floor_settings();
		write_floor(16'hFFFF);
		test_random_sets(60);
		write_floor(16'd0);
		test_directed();
		test_random_sets(60);
		write_floor(16'd1);
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		sample = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		set_len = 0;
		set_dropped = 1'b0;
		floor_reg = lvrd_pkg::FLOOR_RESET;
		mismatch_count = 0;
		sender_gap_pct = 7;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_floor_settings();
		test_random_sets(400);
		// The sender holds off until the block has returned everything.
		drain_results();
		sender_gap_pct = 79;
		write_floor(16'($urandom));
		test_random_sets(400);
		sender_gap_pct = 0;
		write_floor(16'($urandom));
		test_random_sets(400);
		drain_results();
		if (mismatch_count == 0 && pending_results.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
